### src/gtsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtsg_pkg
// Shared types and constants for the group-test status Gibbs step block:
// request and response payloads, configuration register indexes and the
// fixed-point format of the probabilities.
// ----------------------------------------------------------------------------
package gtsg_pkg;

    // Probabilities are unsigned Q0.16; a complement 1-x needs one more bit.
    localparam int PROB_BITS = 16;
    localparam int PW        = PROB_BITS + 1;
    localparam int PRODW     = 2 * PW;
    localparam logic [PW-1:0] ONE_Q = PW'(1) << PROB_BITS;

    // Field widths fixed by the interface.
    localparam int PERSON_BITS = 10;
    localparam int POOL_BITS   = 10;
    localparam int PSIZE_BITS  = 5;
    localparam int COUNT_BITS  = 11;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_POOL_SENSITIVITY  = 3'd0,
        CFG_INDIV_SENSITIVITY = 3'd1,
        CFG_POOL_SPECIFICITY  = 3'd2,
        CFG_INDIV_SPECIFICITY = 3'd3,
        CFG_POOL_SIZE         = 3'd4,
        CFG_INDIVIDUAL_COUNT  = 3'd5
    } cfg_index_t;

    // Request kinds.
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic                   func;
        logic [PERSON_BITS-1:0] person_index;
        logic [POOL_BITS-1:0]   pool_number;
        logic [PROB_BITS-1:0]   prior_prob;
        logic                   pool_positive;
        logic                   retest_positive;
        logic [PROB_BITS-1:0]   uniform_draw;
        logic                   load_status;
    } req_t;

    typedef struct packed {
        logic [PERSON_BITS-1:0] person_out;
        logic                   status_out;
        logic                   degenerate;
    } rsp_t;

    // Operand pair and mode for the shared multiplier.
    typedef struct packed {
        logic [PW-1:0] a;
        logic [PW-1:0] b;
        logic          q_mode;
    } mul_op_t;

    // 1 - x, exact, for a Q0.16 value.
    function automatic logic [PW-1:0] comp_q(input logic [PROB_BITS-1:0] x);
        comp_q = ONE_Q - {1'b0, x};
    endfunction

endpackage

### src/gtsg_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtsg_mul
// Shared registered multiplier. In Q mode it forms (a*b) >> 16 and passes
// the other operand through when one operand equals one; in raw mode it
// returns the full product.
// ----------------------------------------------------------------------------
module gtsg_mul
    import gtsg_pkg::*;
(
    input  logic             clk,
    input  mul_op_t          op,
    output logic [PRODW-1:0] prod
);

    logic [PRODW-1:0] full;
    logic [PRODW-1:0] prod_next;
    logic [PRODW-1:0] prod_reg;

    assign full = PRODW'(op.a) * PRODW'(op.b);

    // Select the Q-format result or the raw product.
    always_comb
    begin
        if (!op.q_mode) begin
            prod_next = full;
        end else if (op.a[PROB_BITS]) begin
            prod_next = PRODW'(op.b);
        end else if (op.b[PROB_BITS]) begin
            prod_next = PRODW'(op.a);
        end else begin
            prod_next = full >> PROB_BITS;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

### src/group_test_status_gibbs_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_test_status_gibbs_step_top
// Gibbs step for the latent status bits of a two-stage pooled test: one
// status bit per individual held in a synchronous memory, loaded or resampled
// one request at a time.
// ----------------------------------------------------------------------------
// A load request writes its bit and answers. A sample request scans the
// members of the named pool after clipping to the individual count (at most
// MAX_POOL_SIZE): the status memory has one read port, so the pool is
// scanned one member per cycle, and then one shared multiplier runs the five
// products of the posterior compare in turn. One request is in work at a
// time; a finished response sits in an output register, so the next request
// is taken while the previous response waits. Status bits have no reset
// value; a bit must be loaded before it is sampled or ORed into a pool.
// Configuration writes are accepted in any cycle and must only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module group_test_status_gibbs_step_top
    import gtsg_pkg::*;
#(
    parameter int MAX_INDIVIDUALS = 1024,
    parameter int MAX_POOL_SIZE   = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  req_t                     req_data,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output rsp_t                     rsp_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int AW  = $clog2(MAX_INDIVIDUALS);
    localparam int PSW = $clog2(MAX_POOL_SIZE + 1);
    localparam int JW  = POOL_BITS + PSW + 1;
    localparam int STEPW = 3;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SETUP  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_MATH   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    typedef enum logic [STEPW-1:0] {
        STEP_P1A  = 3'd0,
        STEP_P1B  = 3'd1,
        STEP_P0A  = 3'd2,
        STEP_P0B  = 3'd3,
        STEP_SUM  = 3'd4,
        STEP_DRAW = 3'd5,
        STEP_CMP  = 3'd6
    } step_t;

    // Configuration registers.
    logic [PROB_BITS-1:0]  pool_se_reg, indiv_se_reg, pool_sp_reg, indiv_sp_reg;
    logic [PSIZE_BITS-1:0] pool_size_reg;
    logic [COUNT_BITS-1:0] indiv_count_reg;

    // Control state.
    state_t            state_reg, state_next;
    step_t             step_reg, step_next;
    logic              pend_reg, pend_next;
    logic              z1_reg, z1_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // Item and datapath registers.
    req_t              item_reg;
    logic [JW-1:0]     j_reg, j_next;
    logic [JW-1:0]     last_reg, last_next;
    logic [PW-1:0]     p1_reg, p1_next;
    logic [PW-1:0]     sum_reg, sum_next;
    logic              bit_reg, bit_next;
    logic              degen_reg, degen_next;
    rsp_t              rsp_reg;

    // Status memory.
    logic              mem [MAX_INDIVIDUALS];
    logic              rd_data_reg;
    logic              mem_we;
    logic              person_in_range;

    // Shared multiplier.
    mul_op_t           mul_op;
    logic [PRODW-1:0]  prod;

    // Pool bounds, worked out in the setup cycle.
    logic [PSW-1:0]    size_eff;
    logic [31:0]       count_eff;
    logic [31:0]       start_w;
    logic [31:0]       last_w;

    // Probability terms.
    logic [PW-1:0]     term_a, term_b, term_c, term_d;

    logic              req_fire;
    logic              rsp_slot_free;

    assign req_ready     = (state_reg == ST_IDLE);
    assign req_fire      = req_valid && req_ready;
    assign cfg_ready     = 1'b1;
    assign rsp_valid     = rsp_valid_reg;
    assign rsp_data      = rsp_reg;
    assign rsp_slot_free = !rsp_valid_reg || rsp_ready;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pool_se_reg     <= PROB_BITS'(62259);
            indiv_se_reg    <= PROB_BITS'(62259);
            pool_sp_reg     <= PROB_BITS'(62259);
            indiv_sp_reg    <= PROB_BITS'(62259);
            pool_size_reg   <= PSIZE_BITS'(4);
            indiv_count_reg <= COUNT_BITS'(1024);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_POOL_SENSITIVITY:  pool_se_reg     <= cfg_data;
                CFG_INDIV_SENSITIVITY: indiv_se_reg    <= cfg_data;
                CFG_POOL_SPECIFICITY:  pool_sp_reg     <= cfg_data;
                CFG_INDIV_SPECIFICITY: indiv_sp_reg    <= cfg_data;
                CFG_POOL_SIZE:         pool_size_reg   <= cfg_data[PSIZE_BITS-1:0];
                CFG_INDIVIDUAL_COUNT:  indiv_count_reg <= cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Clamp pool size and individual count, then bound the pool.
    always_comb
    begin
        if (pool_size_reg == '0) begin
            size_eff = PSW'(1);
        end else if (32'(pool_size_reg) > MAX_POOL_SIZE) begin
            size_eff = PSW'(MAX_POOL_SIZE);
        end else begin
            size_eff = PSW'(pool_size_reg);
        end

        if (indiv_count_reg == '0) begin
            count_eff = 32'd1;
        end else if (32'(indiv_count_reg) > MAX_INDIVIDUALS) begin
            count_eff = 32'(MAX_INDIVIDUALS);
        end else begin
            count_eff = 32'(indiv_count_reg);
        end

        start_w = 32'(item_reg.pool_number) * 32'(size_eff);
        last_w  = start_w + 32'(size_eff) - 32'd1;
        if (last_w > count_eff - 32'd1) begin
            last_w = count_eff - 32'd1;
        end
    end

    // Sensitivity and specificity terms; a factor of one makes a product
    // pass its other operand through, which covers the negative-pool case.
    always_comb
    begin
        if (item_reg.pool_positive) begin
            term_a = {1'b0, pool_se_reg};
            term_b = item_reg.retest_positive ? {1'b0, indiv_se_reg}
                                              : comp_q(indiv_se_reg);
            term_c = z1_reg ? {1'b0, pool_se_reg} : comp_q(pool_sp_reg);
            term_d = item_reg.retest_positive ? comp_q(indiv_sp_reg)
                                              : {1'b0, indiv_sp_reg};
        end else begin
            term_a = comp_q(pool_se_reg);
            term_b = ONE_Q;
            term_c = z1_reg ? comp_q(pool_se_reg) : {1'b0, pool_sp_reg};
            term_d = ONE_Q;
        end
    end

    // Multiplier operand selection by step.
    always_comb
    begin
        mul_op.q_mode = 1'b1;
        mul_op.a      = {1'b0, item_reg.prior_prob};
        mul_op.b      = term_a;
        case (step_reg)
            STEP_P1B:
            begin
                mul_op.a = prod[PW-1:0];
                mul_op.b = term_b;
            end
            STEP_P0A:
            begin
                mul_op.a = comp_q(item_reg.prior_prob);
                mul_op.b = term_c;
            end
            STEP_P0B:
            begin
                mul_op.a = prod[PW-1:0];
                mul_op.b = term_d;
            end
            STEP_DRAW:
            begin
                mul_op.q_mode = 1'b0;
                mul_op.a      = {1'b0, item_reg.uniform_draw};
                mul_op.b      = sum_reg;
            end
            default: ;
        endcase
    end

    gtsg_mul u_mul (
        .clk  (clk),
        .op   (mul_op),
        .prod (prod)
    );

    assign person_in_range = (32'(item_reg.person_index) < MAX_INDIVIDUALS);
    assign mem_we          = (state_reg == ST_FINISH) && rsp_slot_free && person_in_range;

    // Status memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[AW'(item_reg.person_index)] <= bit_reg;
        end
        rd_data_reg <= mem[AW'(j_reg)];
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        j_next         = j_reg;
        last_next      = last_reg;
        p1_next        = p1_reg;
        sum_next       = sum_reg;
        bit_next       = bit_reg;
        degen_next     = degen_reg;
        pend_next      = 1'b0;
        // Fold in the pool member read in the previous cycle.
        z1_next        = z1_reg | (pend_reg & rd_data_reg);
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire) begin
                    if (req_data.func == FUNC_LOAD) begin
                        bit_next   = req_data.load_status;
                        degen_next = 1'b0;
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                j_next     = JW'(start_w);
                last_next  = JW'(last_w);
                z1_next    = 1'b0;
                state_next = (start_w > last_w) ? ST_MATH : ST_SCAN;
                step_next  = STEP_P1A;
            end
            ST_SCAN:
            begin
                if (j_reg <= last_reg) begin
                    pend_next = (32'(j_reg) != 32'(item_reg.person_index));
                    j_next    = j_reg + JW'(1);
                end else begin
                    state_next = ST_MATH;
                    step_next  = STEP_P1A;
                end
            end
            ST_MATH:
            begin
                step_next = step_t'(step_reg + STEPW'(1));
                case (step_reg)
                    STEP_P0A: p1_next  = prod[PW-1:0];
                    STEP_SUM: sum_next = p1_reg + prod[PW-1:0];
                    STEP_CMP:
                    begin
                        degen_next = (sum_reg == '0);
                        bit_next   = (sum_reg != '0) &&
                                     (prod < (PRODW'(p1_reg) << PROB_BITS));
                        state_next = ST_FINISH;
                        step_next  = STEP_P1A;
                    end
                    default: ;
                endcase
            end
            ST_FINISH:
            begin
                if (rsp_slot_free) begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_P1A;
            pend_reg      <= 1'b0;
            z1_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pend_reg      <= pend_next;
            z1_reg        <= z1_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_fire) begin
            item_reg <= req_data;
        end
        j_reg     <= j_next;
        last_reg  <= last_next;
        p1_reg    <= p1_next;
        sum_reg   <= sum_next;
        bit_reg   <= bit_next;
        degen_reg <= degen_next;
        if ((state_reg == ST_FINISH) && rsp_slot_free) begin
            rsp_reg.person_out <= item_reg.person_index;
            rsp_reg.status_out <= bit_reg && person_in_range;
            rsp_reg.degenerate <= degen_reg;
        end
    end

    // A degenerate sample always stores and returns a zero status.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.degenerate |-> !rsp_data.status_out)
    else $error("degenerate response carries a set status bit");

    // A pending member read only follows a scan cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg == ST_SCAN))
    else $error("pool member read pending outside the scan");

    // An accepted request leaves the idle state on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg != ST_IDLE)
    else $error("accepted request did not start");

    // The status memory is written only when a response is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> rsp_valid)
    else $error("status written without a response");

endmodule
